/* src/dcsp_pkg.sv */
// shared types and constants for the colour table segment parser
// no dependencies; used by every module under src
`default_nettype none

package dcsp_pkg;

    // maximum number of entries stored per segment
    localparam int ENTRY_LIMIT = 256;
    localparam int COUNT_W     = 9;

    // depth of the queue between parser front and result formatter
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_TRUNC    = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // byte position within the segment layout
    typedef enum logic [7:0] {
        PH_TABLE_ID = 8'b0000_0001,
        PH_VERSION  = 8'b0000_0010,
        PH_ENTRY_ID = 8'b0000_0100,
        PH_FLAGS    = 8'b0000_1000,
        PH_FIELD0   = 8'b0001_0000,
        PH_FIELD1   = 8'b0010_0000,
        PH_FIELD2   = 8'b0100_0000,
        PH_FIELD3   = 8'b1000_0000
    } phase_t;

    // kind of word handed from front to back
    typedef enum logic [2:0] {
        CMD_ENTRY    = 3'd0,
        CMD_OVERFLOW = 3'd1,
        CMD_REJECT   = 3'd2,
        CMD_TRUNC    = 3'd3,
        CMD_END      = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] seg_length;
        logic        page_open;
    } in_item_t;

    typedef struct packed {
        logic [7:0] table_id;
        logic [3:0] table_version;
        logic [7:0] entry_tag;
        logic [7:0] entry_index;
        logic [7:0] luma;
        logic [7:0] chroma_red;
        logic [7:0] chroma_blue;
        logic [7:0] opacity;
        logic       entry_valid;
        logic       segment_end;
        logic [1:0] status;
    } result_t;

    // classified word: raw scaled fields, final shaping happens in the back
    typedef struct packed {
        cmd_kind_t  kind;
        logic       seg_end;
        logic [7:0] table_id;
        logic [3:0] table_version;
        logic [7:0] entry_tag;
        logic [7:0] entry_index;
        logic [7:0] y;
        logic [7:0] cr;
        logic [7:0] cb;
        logic [7:0] t;
    } cmd_t;

endpackage

`default_nettype wire

/* src/dcsp_front.sv */
// parser front: tracks segment position and classifies each accepted byte
// depends on dcsp_pkg
`default_nettype none

module dcsp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire dcsp_pkg::in_item_t item,
    output logic                   cmd_valid,
    output dcsp_pkg::cmd_t         cmd
);

    logic [15:0]                   bytes_left_reg, bytes_left_next;
    dcsp_pkg::phase_t              phase_reg, phase_next;
    logic [7:0]                    table_id_reg, table_id_next;
    logic [3:0]                    version_reg, version_next;
    logic [7:0]                    pending_id_reg, pending_id_next;
    logic                          full_range_reg, full_range_next;
    logic [23:0]                   partial_reg, partial_next;
    logic [dcsp_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          rejected_reg, rejected_next;

    // working copies after a possible segment restart
    dcsp_pkg::phase_t              cur_phase;
    logic [15:0]                   cur_left;
    logic                          cur_full;
    logic [23:0]                   cur_partial;
    logic [dcsp_pkg::COUNT_W-1:0]  cur_count;
    logic [7:0]                    cur_pending;
    logic                          proceed;
    logic                          entry_done;
    logic [15:0]                   packed_word;
    logic [15:0]                   left_dec;

    // byte classification and next state
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        phase_next      = phase_reg;
        table_id_next   = table_id_reg;
        version_next    = version_reg;
        pending_id_next = pending_id_reg;
        full_range_next = full_range_reg;
        partial_next    = partial_reg;
        count_next      = count_reg;
        rejected_next   = rejected_reg;
        cmd_valid       = 1'b0;
        cmd             = '0;
        proceed         = 1'b0;
        entry_done      = 1'b0;
        cur_phase       = item.first_byte ? dcsp_pkg::PH_TABLE_ID : phase_reg;
        cur_left        = item.first_byte ? item.seg_length : bytes_left_reg;
        cur_full        = item.first_byte ? 1'b0 : full_range_reg;
        cur_partial     = item.first_byte ? 24'd0 : partial_reg;
        cur_count       = item.first_byte ? '0 : count_reg;
        cur_pending     = item.first_byte ? 8'd0 : pending_id_reg;
        left_dec        = cur_left - 16'd1;
        packed_word     = {partial_reg[15:8], item.data_byte};

        if (accept)
        begin
            if (item.first_byte)
            begin
                phase_next      = dcsp_pkg::PH_TABLE_ID;
                pending_id_next = 8'd0;
                full_range_next = 1'b0;
                partial_next    = 24'd0;
                count_next      = '0;
                if (!item.page_open || item.seg_length <= 16'd2)
                begin
                    rejected_next   = 1'b1;
                    bytes_left_next = (item.seg_length != 16'd0) ? left_dec : 16'd0;
                    if (item.seg_length <= 16'd1)
                    begin
                        rejected_next = 1'b0;
                        cmd_valid     = 1'b1;
                        cmd.kind      = dcsp_pkg::CMD_REJECT;
                        cmd.seg_end   = 1'b1;
                    end
                end
                else
                begin
                    rejected_next = 1'b0;
                    proceed       = 1'b1;
                end
            end
            else if (bytes_left_reg == 16'd0)
            begin
                // stray byte outside any segment
                proceed = 1'b0;
            end
            else if (rejected_reg)
            begin
                bytes_left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    rejected_next = 1'b0;
                    cmd_valid     = 1'b1;
                    cmd.kind      = dcsp_pkg::CMD_REJECT;
                    cmd.seg_end   = 1'b1;
                end
            end
            else
            begin
                proceed = 1'b1;
            end
        end

        if (proceed)
        begin
            bytes_left_next = left_dec;
            cmd.entry_tag   = cur_pending;
            case (cur_phase)
                dcsp_pkg::PH_TABLE_ID:
                begin
                    table_id_next = item.data_byte;
                    phase_next    = dcsp_pkg::PH_VERSION;
                end
                dcsp_pkg::PH_VERSION:
                begin
                    version_next = item.data_byte[7:4];
                    phase_next   = dcsp_pkg::PH_ENTRY_ID;
                end
                dcsp_pkg::PH_ENTRY_ID:
                begin
                    pending_id_next = item.data_byte;
                    phase_next      = dcsp_pkg::PH_FLAGS;
                end
                dcsp_pkg::PH_FLAGS:
                begin
                    full_range_next = item.data_byte[0];
                    partial_next    = 24'd0;
                    phase_next      = dcsp_pkg::PH_FIELD0;
                end
                dcsp_pkg::PH_FIELD0:
                begin
                    partial_next = cur_full ? {item.data_byte, 16'd0}
                                            : {8'd0, item.data_byte, 8'd0};
                    phase_next   = dcsp_pkg::PH_FIELD1;
                end
                dcsp_pkg::PH_FIELD1:
                begin
                    if (cur_full)
                    begin
                        partial_next = {cur_partial[23:16], item.data_byte, cur_partial[7:0]};
                        phase_next   = dcsp_pkg::PH_FIELD2;
                    end
                    else
                    begin
                        // reduced entry: Y:6 Cr:4 Cb:4 T:2
                        entry_done = 1'b1;
                        cmd.y      = {packed_word[15:10], 2'b00};
                        cmd.cr     = {packed_word[9:6], 4'd0};
                        cmd.cb     = {packed_word[5:2], 4'd0};
                        cmd.t      = {packed_word[1:0], 6'd0};
                        phase_next = dcsp_pkg::PH_ENTRY_ID;
                    end
                end
                dcsp_pkg::PH_FIELD2:
                begin
                    partial_next = {cur_partial[23:8], item.data_byte};
                    phase_next   = dcsp_pkg::PH_FIELD3;
                end
                dcsp_pkg::PH_FIELD3:
                begin
                    entry_done = 1'b1;
                    cmd.y      = cur_partial[23:16];
                    cmd.cr     = cur_partial[15:8];
                    cmd.cb     = cur_partial[7:0];
                    cmd.t      = item.data_byte;
                    phase_next = dcsp_pkg::PH_ENTRY_ID;
                end
                default:
                begin
                    phase_next = dcsp_pkg::PH_TABLE_ID;
                end
            endcase

            // entry completion, dropped once the table is full
            if (entry_done)
            begin
                cmd_valid = 1'b1;
                if (cur_count >= dcsp_pkg::COUNT_W'(dcsp_pkg::ENTRY_LIMIT))
                begin
                    cmd.kind = dcsp_pkg::CMD_OVERFLOW;
                end
                else
                begin
                    cmd.kind        = dcsp_pkg::CMD_ENTRY;
                    cmd.entry_index = cur_count[7:0];
                    count_next      = cur_count + dcsp_pkg::COUNT_W'(1);
                end
            end

            // last byte of the segment
            if (left_dec == 16'd0)
            begin
                cmd_valid   = 1'b1;
                cmd.seg_end = 1'b1;
                if (phase_next != dcsp_pkg::PH_ENTRY_ID)
                begin
                    cmd.kind = dcsp_pkg::CMD_TRUNC;
                end
                else if (!entry_done)
                begin
                    cmd.kind = dcsp_pkg::CMD_END;
                end
                phase_next = dcsp_pkg::PH_TABLE_ID;
            end

            cmd.table_id      = table_id_next;
            cmd.table_version = version_next;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 16'd0;
            phase_reg      <= dcsp_pkg::PH_TABLE_ID;
            table_id_reg   <= 8'd0;
            version_reg    <= 4'd0;
            pending_id_reg <= 8'd0;
            full_range_reg <= 1'b0;
            partial_reg    <= 24'd0;
            count_reg      <= '0;
            rejected_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            phase_reg      <= phase_next;
            table_id_reg   <= table_id_next;
            version_reg    <= version_next;
            pending_id_reg <= pending_id_next;
            full_range_reg <= full_range_next;
            partial_reg    <= partial_next;
            count_reg      <= count_next;
            rejected_reg   <= rejected_next;
        end
    end

endmodule

`default_nettype wire

/* src/dcsp_queue.sv */
// short word queue between parser front and result formatter
// depends on dcsp_pkg
`default_nettype none

module dcsp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire dcsp_pkg::cmd_t wr_data,
    input  wire logic           rd_en,
    output dcsp_pkg::cmd_t      rd_data,
    output logic                not_empty,
    output logic                is_full
);

    dcsp_pkg::cmd_t                slots_reg [dcsp_pkg::CMD_DEPTH];
    logic [dcsp_pkg::CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dcsp_pkg::CMD_PTR_W:0]   count_reg, count_next;

    assign rd_data   = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == (dcsp_pkg::CMD_PTR_W + 1)'(dcsp_pkg::CMD_DEPTH));

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + (dcsp_pkg::CMD_PTR_W + 1)'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - (dcsp_pkg::CMD_PTR_W + 1)'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + dcsp_pkg::CMD_PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + dcsp_pkg::CMD_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* src/dcsp_back.sv */
// result formatter: shapes queued words into results and holds the output word
// depends on dcsp_pkg
`default_nettype none

module dcsp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_avail,
    input  wire dcsp_pkg::cmd_t cmd,
    output logic                cmd_take,
    input  wire logic           pop,
    output logic                empty,
    output dcsp_pkg::result_t   result
);

    dcsp_pkg::result_t result_reg, result_next;
    logic              valid_reg;
    logic              y_zero;

    assign y_zero   = (cmd.y == 8'd0);
    assign cmd_take = cmd_avail && (!valid_reg || pop);
    assign empty    = !valid_reg;
    assign result   = result_reg;

    // result shaping
    always_comb
    begin
        result_next               = '0;
        result_next.table_id      = cmd.table_id;
        result_next.table_version = cmd.table_version;
        result_next.segment_end   = cmd.seg_end;
        case (cmd.kind)
            dcsp_pkg::CMD_ENTRY:
            begin
                result_next.entry_tag   = cmd.entry_tag;
                result_next.entry_index = cmd.entry_index;
                result_next.luma        = cmd.y;
                result_next.chroma_red  = y_zero ? 8'd0 : cmd.cr;
                result_next.chroma_blue = y_zero ? 8'd0 : cmd.cb;
                result_next.opacity     = y_zero ? 8'd0 : (8'hff - cmd.t);
                result_next.entry_valid = 1'b1;
                result_next.status      = dcsp_pkg::STATUS_OK;
            end
            dcsp_pkg::CMD_OVERFLOW:
            begin
                result_next.entry_tag = cmd.entry_tag;
                result_next.status    = dcsp_pkg::STATUS_OVERFLOW;
            end
            dcsp_pkg::CMD_REJECT:
            begin
                result_next.table_id      = 8'd0;
                result_next.table_version = 4'd0;
                result_next.status        = dcsp_pkg::STATUS_REJECTED;
            end
            dcsp_pkg::CMD_TRUNC:
            begin
                result_next.status = dcsp_pkg::STATUS_TRUNC;
            end
            default:
            begin
                result_next.status = dcsp_pkg::STATUS_OK;
            end
        endcase
    end

    // output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd_take)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

/* src/dvb_clut_segment_parser.sv */
// colour table segment parser top level: front, word queue and formatter
// depends on dcsp_pkg, dcsp_front, dcsp_queue, dcsp_back
//
// usage:
//   input channel: write a word on item and raise push; it is taken on a rising
//   edge with push high and full low. one payload byte per word, the first byte
//   of a segment marked by first_byte, with seg_length and page_open beside it.
//   result channel: while empty is low the oldest result is on result; it is
//   taken on a rising edge with pop high. a result comes for each completed
//   entry and for the last byte of each segment (reject, truncation, overflow
//   reported in status).
//   path: the word for a byte is written into the queue on the edge that takes the
//   byte, and the formatter then registers it into the output word on result.
//   throughput: one byte per cycle, set by the parser front; the
//   four-word queue between front and formatter absorbs stalls of the result
//   side, and full rises only when it and the output word are both occupied.
//   reset: rst_n clears the parser position, the queue and the output word; no
//   segment is open afterwards and stray bytes are dropped until a first byte.
`default_nettype none

module dvb_clut_segment_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire dcsp_pkg::in_item_t item,
    output logic                    empty,
    input  wire logic               pop,
    output dcsp_pkg::result_t       result
);

    logic           accept;
    logic           cmd_valid;
    dcsp_pkg::cmd_t cmd_in;
    dcsp_pkg::cmd_t cmd_head;
    logic           cmd_avail;
    logic           cmd_take;

    assign accept = push && !full;

    // byte classification
    dcsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    // decoupling queue
    dcsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_valid),
        .wr_data   (cmd_in),
        .rd_en     (cmd_take),
        .rd_data   (cmd_head),
        .not_empty (cmd_avail),
        .is_full   (full)
    );

    // result formatting and output word
    dcsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd_head),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

/* tb/dvb_clut_segment_parser_test.sv */
// self-checking bench for the colour table segment parser: directed and random segments
// depends on dcsp_pkg and dvb_clut_segment_parser; predicts each result word from the bytes
`default_nettype none

module dvb_clut_segment_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dcsp_pkg::*;

    localparam int CALM_TAIL  = 150;
    localparam int IDLE_LIMIT = 1000;
    localparam int TARGET     = 1750;

    typedef struct {
        in_item_t w;
        bit       hold;
    } stim_word_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     push  = 1'b0;
    logic     pop   = 1'b0;
    in_item_t item  = '0;
    logic     full;
    logic     empty;
    result_t  result;

    stim_word_t stim[$];
    result_t    pending_results[$];
    result_t    next_want;

    int send_gap   = 0;
    int pop_gap    = 0;
    int idle_count = 0;
    int stray_cnt  = 0;
    int mismatches = 0;
    int bytes_in   = 0;
    int n_entries  = 0;
    int n_reject   = 0;
    int n_trunc    = 0;
    int n_overflow = 0;

    // parser state mirrored by the predictor
    logic [15:0] left_cnt   = '0;
    phase_t      cur_phase  = PH_TABLE_ID;
    logic [7:0]  tbl_id     = '0;
    logic [3:0]  tbl_ver    = '0;
    logic [7:0]  ent_id     = '0;
    logic        ent_full   = 1'b0;
    logic [23:0] ent_fields = '0;
    logic [8:0]  ent_count  = '0;
    logic        seg_reject = 1'b0;

    dvb_clut_segment_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shape a completed entry, or report it as dropped once the table is full
    task automatic finish_color(inout result_t r, input logic [7:0] y, input logic [7:0] cr,
                                input logic [7:0] cb, input logic [7:0] t);
        r.entry_tag = ent_id;
        if (ent_count >= ENTRY_LIMIT)
        begin
            r.status = STATUS_OVERFLOW;
            return;
        end
        r.entry_index = ent_count[7:0];
        r.luma        = y;
        r.chroma_red  = (y == 8'd0) ? 8'd0 : cr;
        r.chroma_blue = (y == 8'd0) ? 8'd0 : cb;
        r.opacity     = (y == 8'd0) ? 8'd0 : 8'hff - t;
        r.entry_valid = 1'b1;
        ent_count     = ent_count + 9'd1;
    endtask

    // advance the parser by one accepted byte and queue the word it should produce
    task automatic predict_palette_byte(input in_item_t w);
        result_t     r;
        logic        emit;
        logic [15:0] packed_fields;
        r    = '0;
        emit = 1'b0;
        r.segment_end = 1'b1;
        r.status      = STATUS_REJECTED;
        if (w.first_byte)
        begin
            cur_phase  = PH_TABLE_ID;
            ent_id     = '0;
            ent_full   = 1'b0;
            ent_fields = '0;
            ent_count  = '0;
            if (!w.page_open || w.seg_length <= 16'd2)
            begin
                left_cnt   = (w.seg_length == 16'd0) ? 16'd0 : w.seg_length - 16'd1;
                seg_reject = (left_cnt != 16'd0);
                if (left_cnt == 16'd0)
                    pending_results.push_back(r);
                return;
            end
            seg_reject = 1'b0;
            left_cnt   = w.seg_length;
        end
        else if (left_cnt == 16'd0)
            return;
        else if (seg_reject)
        begin
            left_cnt = left_cnt - 16'd1;
            if (left_cnt == 16'd0)
            begin
                seg_reject = 1'b0;
                pending_results.push_back(r);
            end
            return;
        end

        r        = '0;
        left_cnt = left_cnt - 16'd1;
        case (cur_phase)
            PH_TABLE_ID:
            begin
                tbl_id    = w.data_byte;
                cur_phase = PH_VERSION;
            end
            PH_VERSION:
            begin
                tbl_ver   = w.data_byte[7:4];
                cur_phase = PH_ENTRY_ID;
            end
            PH_ENTRY_ID:
            begin
                ent_id    = w.data_byte;
                cur_phase = PH_FLAGS;
            end
            PH_FLAGS:
            begin
                ent_full   = w.data_byte[0];
                ent_fields = '0;
                cur_phase  = PH_FIELD0;
            end
            PH_FIELD0:
            begin
                ent_fields = ent_full ? {w.data_byte, 16'h0} : {8'h0, w.data_byte, 8'h0};
                cur_phase  = PH_FIELD1;
            end
            PH_FIELD1:
            begin
                if (ent_full)
                begin
                    ent_fields[15:8] = w.data_byte;
                    cur_phase        = PH_FIELD2;
                end
                else
                begin
                    // reduced entry: Y 6 bits, Cr 4, Cb 4, T 2
                    packed_fields = {ent_fields[15:8], w.data_byte};
                    finish_color(r, {packed_fields[15:10], 2'b00}, {packed_fields[9:6], 4'h0},
                                 {packed_fields[5:2], 4'h0}, {packed_fields[1:0], 6'h00});
                    emit      = 1'b1;
                    cur_phase = PH_ENTRY_ID;
                end
            end
            PH_FIELD2:
            begin
                ent_fields[7:0] = w.data_byte;
                cur_phase       = PH_FIELD3;
            end
            default:
            begin
                finish_color(r, ent_fields[23:16], ent_fields[15:8], ent_fields[7:0],
                             w.data_byte);
                emit      = 1'b1;
                cur_phase = PH_ENTRY_ID;
            end
        endcase

        // last byte of the segment, truncated when an entry is still open
        if (left_cnt == 16'd0)
        begin
            emit = 1'b1;
            if (cur_phase != PH_ENTRY_ID)
            begin
                r        = '0;
                r.status = STATUS_TRUNC;
            end
            r.segment_end = 1'b1;
            cur_phase     = PH_TABLE_ID;
        end
        if (emit)
        begin
            r.table_id      = tbl_id;
            r.table_version = tbl_ver;
            pending_results.push_back(r);
        end
    endtask

    task automatic cmp_field(input string fname, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // words other than the first carry random length and page bits, which must be ignored
    task automatic add_byte(input logic [7:0] d, input logic first, input logic [15:0] len,
                            input logic page, input bit hold);
        stim_word_t s;
        s.w.data_byte  = d;
        s.w.first_byte = first;
        s.w.seg_length = first ? len : 16'($urandom_range(0, 65535));
        s.w.page_open  = first ? page : 1'($urandom_range(0, 1));
        s.hold         = hold;
        stim.push_back(s);
    endtask

    // well-formed segment body with random content; len_adj shortens the declared length
    task automatic add_segment(input int n_ent, input int full_pct, input int len_adj,
                               input bit page, input bit hold);
        logic [7:0] body[$];
        logic [7:0] b;
        bit         full_range;
        int         total;
        int         n_send;
        int         i;
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < n_ent; i++)
        begin
            full_range = ($urandom_range(1, 100) <= full_pct);
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back({7'($urandom_range(0, 127)), full_range});
            b = 8'($urandom_range(0, 255));
            if (full_range)
            begin
                if ($urandom_range(0, 7) == 0)
                    b = 8'd0;
                body.push_back(b);
                body.push_back(8'($urandom_range(0, 255)));
                body.push_back(8'($urandom_range(0, 255)));
                body.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    b[7:2] = 6'd0;
                body.push_back(b);
                body.push_back(8'($urandom_range(0, 255)));
            end
        end
        total = body.size() + len_adj;
        if (total < 0)
            total = 0;
        n_send = (total == 0) ? 1 : total;
        for (i = 0; i < n_send; i++)
            add_byte(body[i], i == 0, 16'(total), page, hold && i == 0);
    endtask

    // driver: presents the next word, holds it while full, idles in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            item     <= '0;
            send_gap <= 0;
        end
        else if (!push || !full)
        begin
            if (send_gap != 0)
            begin
                push     <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (stim.size() == 0 ||
                     (stim[0].hold && (push || pending_results.size() != 0)))
                push <= 1'b0;
            else if (stim.size() > CALM_TAIL && $urandom_range(0, 15) == 0)
            begin
                push     <= 1'b0;
                send_gap <= $urandom_range(0, 18);
            end
            else
            begin
                item <= stim[0].w;
                push <= 1'b1;
                void'(stim.pop_front());
            end
        end
    end

    // monitor: check the popped word, then predict from the accepted input word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            pop_gap <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %h", $time,
                             result);
                    mismatches++;
                end
                else
                begin
                    next_want = pending_results.pop_front();
                    cmp_field("table_id", next_want.table_id, result.table_id);
                    cmp_field("table_version", next_want.table_version, result.table_version);
                    cmp_field("entry_tag", next_want.entry_tag, result.entry_tag);
                    cmp_field("entry_index", next_want.entry_index, result.entry_index);
                    cmp_field("luma", next_want.luma, result.luma);
                    cmp_field("chroma_red", next_want.chroma_red, result.chroma_red);
                    cmp_field("chroma_blue", next_want.chroma_blue, result.chroma_blue);
                    cmp_field("opacity", next_want.opacity, result.opacity);
                    cmp_field("entry_valid", next_want.entry_valid, result.entry_valid);
                    cmp_field("segment_end", next_want.segment_end, result.segment_end);
                    cmp_field("status", next_want.status, result.status);
                    n_entries  += next_want.entry_valid;
                    n_reject   += (next_want.status == STATUS_REJECTED);
                    n_trunc    += (next_want.status == STATUS_TRUNC);
                    n_overflow += (next_want.status == STATUS_OVERFLOW);
                end
            end
            if (push && !full)
            begin
                predict_palette_byte(item);
                bytes_in++;
            end
            // result side stalls in bursts
            if (pop_gap != 0)
            begin
                pop     <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else if (stim.size() > CALM_TAIL && $urandom_range(0, 15) == 0)
            begin
                pop     <= 1'b0;
                pop_gap <= $urandom_range(0, 18);
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_count <= 0;
            else if (idle_count >= IDLE_LIMIT)
            begin
                $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    initial
    begin
        int r;
        int k;
        int i;

        // directed: stray byte, short and page-less rejects
        add_byte(8'hff, 1'b0, 16'hffff, 1'b1, 1'b0);
        add_byte(8'h00, 1'b1, 16'd0, 1'b1, 1'b0);
        add_byte(8'hff, 1'b1, 16'd1, 1'b1, 1'b0);
        add_byte(8'h12, 1'b1, 16'd2, 1'b1, 1'b0);
        add_byte(8'h34, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'h56, 1'b1, 16'd3, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        // reduced entry at full scale, then full-range entry with zero luma ending the segment
        add_byte(8'hff, 1'b1, 16'd12, 1'b1, 1'b0);
        add_byte(8'hf0, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'hff, 1'b0, 16'd0, 1'b0, 1'b0);
        // segment ending inside an entry
        add_byte(8'h00, 1'b1, 16'd4, 1'b1, 1'b0);
        add_byte(8'h0f, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'h5a, 1'b0, 16'd0, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 16'd0, 1'b0, 1'b0);
        // longest segment abandoned by a new first byte
        add_byte(8'haa, 1'b1, 16'hffff, 1'b1, 1'b0);
        add_byte(8'h55, 1'b0, 16'd0, 1'b0, 1'b0);

        // one segment past the entry limit, started only once all results are in
        add_segment(ENTRY_LIMIT + 2, 0, 0, 1'b1, 1'b1);

        // random mix: mostly well-formed segments, then cuts, rejects and noise
        while (stim.size() - stray_cnt < TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                add_segment($urandom_range(0, 6), 50, 0, 1'b1, $urandom_range(0, 19) == 0);
            else if (r < 72)
                add_segment($urandom_range(1, 5), 50, -$urandom_range(1, 3), 1'b1, 1'b0);
            else if (r < 76)
                add_segment($urandom_range(0, 3), 50, 0, 1'b0, 1'b0);
            else if (r < 80)
                add_segment(0, 50, -$urandom_range(0, 2), 1'b1, 1'b0);
            else if (r < 92)
            begin
                add_byte(8'($urandom_range(0, 255)), 1'b1, 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)), 1'b0);
                k = $urandom_range(0, 6);
                for (i = 0; i < k; i++)
                    add_byte(8'($urandom_range(0, 255)), 1'b0, 16'd0, 1'b0, 1'b0);
            end
            else
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                    add_byte(8'($urandom_range(0, 255)), 1'b0, 16'd0, 1'b0, 1'b0);
                stray_cnt += k;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every word to be taken and every result to arrive
        while (stim.size() != 0 || push)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d payload bytes; results: %0d stored entries, %0d rejected segments,",
                 bytes_in, n_entries, n_reject);
        $display("%0d truncated segments, %0d entries dropped past the table limit",
                 n_trunc, n_overflow);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/dcsp_pkg.sv
src/dcsp_front.sv
src/dcsp_queue.sv
src/dcsp_back.sv
src/dvb_clut_segment_parser.sv
tb/dvb_clut_segment_parser_test.sv
